/* rtl/laplacian_stencil_2d_defines.svh */
// Assertion macros shared by the stencil RTL.
`ifndef LAPLACIAN_STENCIL_2D_DEFINES_SVH
`define LAPLACIAN_STENCIL_2D_DEFINES_SVH

`ifndef ASSERT_OFF
`define LAP2D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LAP2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LAP2D_ASSERT(lbl, clk, rst_n, prop, msg)
`define LAP2D_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/lap2d_pkg.sv */
`default_nettype none

package lap2d_pkg;

    localparam int MAX_COLS_DEF       = 1024;
    localparam int MAX_HALF_ORDER_DEF = 4;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 32;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int PROD_W   = PAIR_W + COEF_W;
    localparam int SUM_W    = PROD_W + 3;
    localparam int D_W      = SUM_W - 27;
    localparam int HI_W     = D_W;
    localparam int T_W      = D_W + 9;
    localparam int TERM_W   = T_W + 1;
    localparam int LAP_W    = 32;
    localparam int ROW_W    = 16;
    localparam int LEN_W    = 11;
    localparam int HO_W     = 3;
    localparam int INV_W    = 32;

    typedef enum logic [2:0] {
        REG_HALF_ORDER,
        REG_ROW_LEN,
        REG_NUM_ROWS,
        REG_INV_DX2,
        REG_INV_DZ2
    } reg_idx_t;

    // center tap, then taps at distance 1..4; Q4.28
    localparam logic signed [COEF_W-1:0] COEF_TAB [4][5] = '{
        '{-32'sd536870912, 32'sd268435456, 32'sd0, 32'sd0, 32'sd0},
        '{-32'sd671088640, 32'sd357913941, -32'sd22369621, 32'sd0, 32'sd0},
        '{-32'sd730740964, 32'sd402653184, -32'sd40265318, 32'sd2982616, 32'sd0},
        '{-32'sd764295396, 32'sd429496730, -32'sd53687091, 32'sd6817408,
          -32'sd479349}
    };

endpackage

`default_nettype wire

/* rtl/laplacian_stencil_2d.sv */
// A result word reaches the output register from the sample that completes its window
// through the store read, window, product, sum and scaling registers.
// Throughput: one sample per cycle; banked line stores give all taps in one read.
// The pipeline holds as a whole only while the output register waits on m_ready.
// Reset (synchronous, active low) clears counters, pipeline valids and config to
// defaults; line store contents stay undefined until written.
`default_nettype none
`include "laplacian_stencil_2d_defines.svh"

module laplacian_stencil_2d import lap2d_pkg::*; #(
    parameter int MAX_COLS       = MAX_COLS_DEF,
    parameter int MAX_HALF_ORDER = MAX_HALF_ORDER_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [4:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [SAMPLE_W-1:0]   s_sample,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [LAP_W-1:0]           m_laplacian,
    output logic [ROW_W-1:0]                  m_center_row,
    output logic [$clog2(MAX_COLS)-1:0]       m_center_col,
    output logic                              m_frame_last
);

    localparam int RING_ROWS = 2 * MAX_HALF_ORDER;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int BANK_W    = $clog2(RING_ROWS);
    localparam int CMP_W     = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;
    localparam int TAP_N     = MAX_HALF_ORDER;
    localparam int TI_W      = $clog2(TAP_N + 1);
    localparam int DLY       = 4;

    // ---------------- configuration ----------------
    logic [HO_W-1:0]  half_order_reg;
    logic [LEN_W-1:0] row_len_reg;
    logic [ROW_W-1:0] num_rows_reg;
    logic [INV_W-1:0] inv_dx2_reg;
    logic [INV_W-1:0] inv_dz2_reg;
    reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_order_reg <= HO_W'(4);
            row_len_reg    <= LEN_W'(1024);
            num_rows_reg   <= ROW_W'(1024);
            inv_dx2_reg    <= 32'h0100_0000;
            inv_dz2_reg    <= 32'h0100_0000;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_HALF_ORDER: half_order_reg <= pwdata[HO_W-1:0];
                REG_ROW_LEN:    row_len_reg    <= pwdata[LEN_W-1:0];
                REG_NUM_ROWS:   num_rows_reg   <= pwdata[ROW_W-1:0];
                REG_INV_DX2:    inv_dx2_reg    <= pwdata;
                REG_INV_DZ2:    inv_dz2_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HALF_ORDER: prdata = 32'(half_order_reg);
            REG_ROW_LEN:    prdata = 32'(row_len_reg);
            REG_NUM_ROWS:   prdata = 32'(num_rows_reg);
            REG_INV_DX2:    prdata = inv_dx2_reg;
            REG_INV_DZ2:    prdata = inv_dz2_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- effective settings ----------------
    logic [HO_W-1:0]  h_eff;
    logic [CMP_W-1:0] len_eff;
    logic [ROW_W-1:0] rows_eff;

    always_comb begin
        if (half_order_reg == '0) begin
            h_eff = HO_W'(1);
        end else if (half_order_reg > HO_W'(MAX_HALF_ORDER)) begin
            h_eff = HO_W'(MAX_HALF_ORDER);
        end else begin
            h_eff = half_order_reg;
        end
        if (row_len_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(row_len_reg) > CMP_W'(MAX_COLS)) begin
            len_eff = CMP_W'(MAX_COLS);
        end else begin
            len_eff = CMP_W'(row_len_reg);
        end
        rows_eff = (num_rows_reg == '0) ? ROW_W'(1) : num_rows_reg;
    end

    // ---------------- stage 0: counters and store access ----------------
    logic              adv;
    logic              accept;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [BANK_W-1:0] wb_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [BANK_W-1:0] wb_next;
    logic [CMP_W-1:0]  col_x;
    logic [CMP_W-1:0]  h_x;
    logic [CMP_W-1:0]  b_sum;
    logic [COL_W-1:0]  b_col;
    logic              emit;
    logic              is_last;
    logic              col_last;
    logic              row_wrap;
    logic              out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    always_comb begin
        col_x    = CMP_W'(col_reg);
        h_x      = CMP_W'(h_eff);
        emit     = (row_reg >= (ROW_W'(h_eff) << 1)) && (row_reg < rows_eff)
                && (col_x >= h_x) && (col_x + h_x < len_eff);
        is_last  = (row_reg == rows_eff - ROW_W'(1)) && (col_x + h_x + CMP_W'(1) == len_eff);
        col_last = (col_x + CMP_W'(1) >= len_eff);
        row_wrap = ({1'b0, row_reg} + 17'd1 >= {1'b0, rows_eff});
        b_sum    = col_x + h_x;
        b_col    = (b_sum >= CMP_W'(MAX_COLS)) ? COL_W'(b_sum - CMP_W'(MAX_COLS))
                                               : COL_W'(b_sum);
        if (col_last) begin
            col_next = '0;
            if (row_wrap) begin
                row_next = '0;
                wb_next  = '0;
            end else begin
                row_next = row_reg + ROW_W'(1);
                wb_next  = (wb_reg == BANK_W'(RING_ROWS - 1)) ? '0 : wb_reg + BANK_W'(1);
            end
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
            wb_next  = wb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            wb_reg  <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            wb_reg  <= wb_next;
        end
    end

    logic [SAMPLE_W-1:0] rda [RING_ROWS];
    logic [SAMPLE_W-1:0] rdb [RING_ROWS];

    lap2d_line_store #(
        .MAX_COLS  (MAX_COLS),
        .RING_ROWS (RING_ROWS)
    ) u_store (
        .aclk   (aclk),
        .en     (adv),
        .we     (accept),
        .wbank  (wb_reg),
        .wcol   (col_reg),
        .wdata  (s_sample),
        .acol   (col_reg),
        .bcol   (b_col),
        .a_data (rda),
        .b_data (rdb)
    );

    // ---------------- stage 1: window assembly ----------------
    logic                       v1_reg;
    logic                       e1_reg;
    logic                       last1_reg;
    logic [ROW_W-1:0]           cr1_reg;
    logic [COL_W-1:0]           col1_reg;
    logic [HO_W-1:0]            h1_reg;
    logic [BANK_W-1:0]          wb1_reg;
    logic signed [SAMPLE_W-1:0] sample1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg      <= emit;
            last1_reg   <= is_last;
            cr1_reg     <= row_reg - ROW_W'(h_eff);
            col1_reg    <= col_reg;
            h1_reg      <= h_eff;
            wb1_reg     <= wb_reg;
            sample1_reg <= s_sample;
        end
    end

    // bank holding the row j rows above the one at write bank wb
    function automatic logic [BANK_W-1:0] bank_of(input logic [BANK_W-1:0] wb,
                                                  input logic [3:0] j);
        logic [4:0] s;
        s = 5'(wb) + 5'(RING_ROWS) - 5'(j);
        if (s >= 5'(RING_ROWS)) begin
            s = s - 5'(RING_ROWS);
        end
        return s[BANK_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] tap_a_reg [TAP_N];
    logic signed [SAMPLE_W-1:0] tap_b_reg [TAP_N];
    logic signed [SAMPLE_W-1:0] tap_a_nx  [TAP_N+1];
    logic signed [SAMPLE_W-1:0] tap_b_nx  [TAP_N+1];
    logic signed [SAMPLE_W-1:0] ctr1;
    logic signed [PAIR_W-1:0]   px1 [1:TAP_N];
    logic signed [PAIR_W-1:0]   pz1 [1:TAP_N];

    always_comb begin
        logic [BANK_W-1:0]          bc;
        logic signed [SAMPLE_W-1:0] up;
        logic signed [SAMPLE_W-1:0] below;
        logic [HO_W-1:0]            dk;
        up          = '0;
        below       = '0;
        dk          = '0;
        bc          = bank_of(wb1_reg, 4'(h1_reg));
        tap_a_nx[0] = $signed(rda[bc]);
        tap_b_nx[0] = $signed(rdb[bc]);
        for (int i = 1; i <= TAP_N; i++) begin
            tap_a_nx[i] = tap_a_reg[i-1];
            tap_b_nx[i] = tap_b_reg[i-1];
        end
        ctr1 = tap_a_nx[0];
        for (int k = 1; k <= TAP_N; k++) begin
            if (HO_W'(k) <= h1_reg) begin
                dk    = h1_reg - HO_W'(k);
                up    = $signed(rda[bank_of(wb1_reg, 4'(h1_reg) + 4'(k))]);
                below = (dk == '0) ? sample1_reg : $signed(rda[bank_of(wb1_reg, 4'(dk))]);
                px1[k] = $signed({up[SAMPLE_W-1], up}) + $signed({below[SAMPLE_W-1], below});
                pz1[k] = $signed({tap_a_nx[k][SAMPLE_W-1], tap_a_nx[k]})
                       + $signed({tap_b_nx[TI_W'(dk)][SAMPLE_W-1], tap_b_nx[TI_W'(dk)]});
            end else begin
                px1[k] = '0;
                pz1[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            for (int i = 0; i < TAP_N; i++) begin
                tap_a_reg[i] <= tap_a_nx[i];
                tap_b_reg[i] <= tap_b_nx[i];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic                       v2_reg;
    logic                       last2_reg;
    logic [ROW_W-1:0]           cr2_reg;
    logic [COL_W-1:0]           col2_reg;
    logic [HO_W-1:0]            h2_reg;
    logic signed [SAMPLE_W-1:0] ctr2_reg;
    logic signed [PAIR_W-1:0]   px2_reg [1:TAP_N];
    logic signed [PAIR_W-1:0]   pz2_reg [1:TAP_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && e1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last2_reg <= last1_reg;
            cr2_reg   <= cr1_reg;
            col2_reg  <= col1_reg;
            h2_reg    <= h1_reg;
            ctr2_reg  <= ctr1;
            for (int k = 1; k <= TAP_N; k++) begin
                px2_reg[k] <= px1[k];
                pz2_reg[k] <= pz1[k];
            end
        end
    end

    logic [1:0]               hsel2;
    logic signed [PROD_W-1:0] pc2;
    logic signed [PROD_W-1:0] qx2 [1:TAP_N];
    logic signed [PROD_W-1:0] qz2 [1:TAP_N];

    always_comb begin
        hsel2 = 2'(h2_reg - HO_W'(1));
        pc2   = $signed(ctr2_reg) * COEF_TAB[hsel2][0];
        for (int k = 1; k <= TAP_N; k++) begin
            qx2[k] = px2_reg[k] * COEF_TAB[hsel2][k];
            qz2[k] = pz2_reg[k] * COEF_TAB[hsel2][k];
        end
    end

    // ---------------- stage 3: sums ----------------
    logic                     v3_reg;
    logic                     last3_reg;
    logic [ROW_W-1:0]         cr3_reg;
    logic [COL_W-1:0]         col3_reg;
    logic signed [PROD_W-1:0] pc3_reg;
    logic signed [PROD_W-1:0] qx3_reg [1:TAP_N];
    logic signed [PROD_W-1:0] qz3_reg [1:TAP_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last3_reg <= last2_reg;
            cr3_reg   <= cr2_reg;
            col3_reg  <= col2_reg;
            pc3_reg   <= pc2;
            for (int k = 1; k <= TAP_N; k++) begin
                qx3_reg[k] <= qx2[k];
                qz3_reg[k] <= qz2[k];
            end
        end
    end

    logic signed [SUM_W-1:0] sx3;
    logic signed [SUM_W-1:0] sz3;

    always_comb begin
        sx3 = SUM_W'(pc3_reg);
        sz3 = SUM_W'(pc3_reg);
        for (int k = 1; k <= TAP_N; k++) begin
            sx3 = sx3 + SUM_W'(qx3_reg[k]);
            sz3 = sz3 + SUM_W'(qz3_reg[k]);
        end
    end

    // ---------------- stage 4..7: scaling ----------------
    logic signed [SUM_W-1:0] sx4_reg;
    logic signed [SUM_W-1:0] sz4_reg;
    logic                    vd_reg    [DLY];
    logic                    lastd_reg [DLY];
    logic [ROW_W-1:0]        crd_reg   [DLY];
    logic [COL_W-1:0]        cold_reg  [DLY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DLY; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DLY; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx4_reg      <= sx3;
            sz4_reg      <= sz3;
            lastd_reg[0] <= last3_reg;
            crd_reg[0]   <= cr3_reg;
            cold_reg[0]  <= col3_reg;
            for (int i = 1; i < DLY; i++) begin
                lastd_reg[i] <= lastd_reg[i-1];
                crd_reg[i]   <= crd_reg[i-1];
                cold_reg[i]  <= cold_reg[i-1];
            end
        end
    end

    logic signed [TERM_W-1:0] tx;
    logic signed [TERM_W-1:0] tz;

    lap2d_scale u_scale_x (
        .aclk   (aclk),
        .en     (adv),
        .sum_in (sx4_reg),
        .inv    (inv_dx2_reg),
        .term   (tx)
    );

    lap2d_scale u_scale_z (
        .aclk   (aclk),
        .en     (adv),
        .sum_in (sz4_reg),
        .inv    (inv_dz2_reg),
        .term   (tz)
    );

    // ---------------- output register ----------------
    logic signed [TERM_W:0]    lap_sum;
    logic signed [LAP_W-1:0]   lap_sat;
    logic signed [LAP_W-1:0]   lap_out_reg;
    logic [ROW_W-1:0]          row_out_reg;
    logic [COL_W-1:0]          col_out_reg;
    logic                      last_out_reg;

    always_comb begin
        lap_sum = $signed({tx[TERM_W-1], tx}) + $signed({tz[TERM_W-1], tz});
        if (lap_sum[TERM_W:LAP_W-1] == '0 || lap_sum[TERM_W:LAP_W-1] == '1) begin
            lap_sat = lap_sum[LAP_W-1:0];
        end else if (lap_sum[TERM_W]) begin
            lap_sat = {1'b1, {(LAP_W-1){1'b0}}};
        end else begin
            lap_sat = {1'b0, {(LAP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vd_reg[DLY-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lap_out_reg  <= lap_sat;
            row_out_reg  <= crd_reg[DLY-1];
            col_out_reg  <= cold_reg[DLY-1];
            last_out_reg <= lastd_reg[DLY-1];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_laplacian  = lap_out_reg;
    assign m_center_row = row_out_reg;
    assign m_center_col = col_out_reg;
    assign m_frame_last = last_out_reg;

    // ---------------- checks ----------------
    `LAP2D_ASSERT(a_bank_range, aclk, aresetn, wb_reg < BANK_W'(RING_ROWS - 1) || wb_reg == BANK_W'(RING_ROWS - 1), "write bank out of ring range")
    `LAP2D_ASSERT(a_out_from_pipe, aclk, aresetn, $rose(out_valid_reg) |-> $past(vd_reg[DLY-1]), "output word without a pipeline word")
    `LAP2D_ASSERT(a_stall_holds, aclk, aresetn, !adv |=> $stable(v2_reg) && $stable(v3_reg) && $stable(col_reg), "pipeline moved while stalled")

endmodule

`default_nettype wire

/* rtl/lap2d_line_store.sv */
`default_nettype none

module lap2d_line_store import lap2d_pkg::*; #(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int RING_ROWS = 2 * MAX_HALF_ORDER_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic                         we,
    input  wire logic [$clog2(RING_ROWS)-1:0] wbank,
    input  wire logic [$clog2(MAX_COLS)-1:0]  wcol,
    input  wire logic [SAMPLE_W-1:0]          wdata,
    input  wire logic [$clog2(MAX_COLS)-1:0]  acol,
    input  wire logic [$clog2(MAX_COLS)-1:0]  bcol,
    output logic      [SAMPLE_W-1:0]          a_data [RING_ROWS],
    output logic      [SAMPLE_W-1:0]          b_data [RING_ROWS]
);

    localparam int BANK_W = $clog2(RING_ROWS);

    // one bank per buffered row; port A feeds the column, port B runs ahead
    for (genvar g = 0; g < RING_ROWS; g++) begin : g_bank
        logic [SAMPLE_W-1:0] mem [MAX_COLS];

        always_ff @(posedge aclk) begin
            if (en) begin
                a_data[g] <= mem[acol];
                b_data[g] <= mem[bcol];
                if (we && wbank == BANK_W'(g)) begin
                    mem[wcol] <= wdata;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/lap2d_scale.sv */
`default_nettype none

module lap2d_scale import lap2d_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [SUM_W-1:0]  sum_in,
    input  wire logic        [INV_W-1:0]  inv,
    output logic signed      [TERM_W-1:0] term
);

    logic [SUM_W-1:0]  mag;
    logic [SUM_W:0]    rsum;
    logic [D_W-1:0]    d_reg;
    logic              neg_a_reg;
    logic [63:0]       lo_reg;
    logic [HI_W-1:0]   hi_reg;
    logic              neg_b_reg;
    logic [64:0]       rnd;
    logic [T_W-1:0]    t;
    logic signed [TERM_W-1:0] term_reg;

    // Q.44 to Q16.16, half away from zero
    always_comb begin
        mag  = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
        rsum = {1'b0, mag} + (SUM_W + 1)'(28'h8000000);
    end

    always_comb begin
        rnd = {1'b0, lo_reg} + 65'd8388608;
        t   = T_W'({hi_reg, 8'b0}) + T_W'(rnd[64:24]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= rsum[SUM_W:28];
            neg_a_reg <= sum_in[SUM_W-1];
            lo_reg    <= d_reg[31:0] * inv;
            hi_reg    <= d_reg[D_W-1:32] * inv;
            neg_b_reg <= neg_a_reg;
            term_reg  <= neg_b_reg ? -$signed({1'b0, t}) : $signed({1'b0, t});
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire
